### rtl/bol_pkg.sv
// shared types and constants of the bounded ordered list engine
`default_nettype none
package bol_pkg;

  typedef logic signed [31:0] value_t;

  typedef enum logic [3:0] {
    ModeInsFront = 4'd0,
    ModeInsEnd   = 4'd1,
    ModeInsPos   = 4'd2,
    ModeDelFront = 4'd3,
    ModeDelEnd   = 4'd4,
    ModeDelPos   = 4'd5,
    ModeSearch   = 4'd6,
    ModeLength   = 4'd7,
    ModeDump     = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatEmpty    = 3'd1,
    StatFull     = 3'd2,
    StatBadPos   = 3'd3,
    StatNotFound = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CmdHold   = 2'd0,
    CmdInsert = 2'd1,
    CmdDelete = 2'd2,
    CmdRotate = 2'd3
  } cell_cmd_e;

  // most beats a single dump produces
  localparam int DumpLimit = 16;

endpackage
`default_nettype wire

### rtl/bol_if.sv
// handshake channels for operation requests and result beats
`default_nettype none
interface bol_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        mode;
  logic signed [31:0] value;
  logic [4:0]        position;

  modport source (output valid, mode, value, position, input ready);
  modport sink (input valid, mode, value, position, output ready);
endinterface

interface bol_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [31:0] element;
  logic [4:0]        index;
  logic              last;

  modport source (output valid, status, element, index, last, input ready);
  modport sink (input valid, status, element, index, last, output ready);
endinterface
`default_nettype wire

### rtl/bounded_ordered_list_engine_core.sv
// list engine: insert, delete, search, length and dump over a chain of cells
// inserts, length and rejected requests: result loaded into the output register on accept
// search, delete and dump rotate the whole chain once, and a delete then closes the gap
// in a shift state; a dump sends one beat per rotation step over the first entries, up to DumpLimit
// rotation steps pause while a result beat waits at the output
// reset clears the element count and control state; cell contents stay undefined
`default_nettype none
module bounded_ordered_list_engine_core
  import bol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bol_in_if.sink    in_i,
  bol_out_if.source out_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StShift = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] target_q, target_d;
  mode_e         op_q, op_d;
  value_t        key_q, key_d;
  logic          found_q, found_d;
  logic [IW-1:0] fidx_q, fidx_d;
  value_t        removed_q, removed_d;

  logic          out_valid_q;
  status_e       out_status_q;
  value_t        out_element_q;
  logic [4:0]    out_index_q;
  logic          out_last_q;

  logic          load_out;
  status_e       load_status;
  value_t        load_element;
  logic [4:0]    load_index;
  logic          load_last;

  cell_cmd_e     cell_cmd;
  logic [IW-1:0] cell_pos;
  value_t        cell_data [CAPACITY];

  logic          out_free, accept, last_step;
  logic [XW-1:0] cnt_x, pos_x, ins_pos_x, del_pos_x, k_x, dump_n_x;
  logic          full, empty, hit;
  mode_e         req_mode;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle) && out_free;
  assign accept     = in_i.valid && in_i.ready;

  assign req_mode  = mode_e'(in_i.mode);
  assign cnt_x     = XW'(count_q);
  assign pos_x     = XW'(in_i.position);
  assign k_x       = XW'(k_q);
  assign full      = (count_q == CW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign last_step = (k_q == IW'(CAPACITY - 1));
  assign dump_n_x  = (cnt_x < XW'(DumpLimit)) ? cnt_x : XW'(DumpLimit);
  assign hit       = (cell_data[0] == key_q) && (k_x < cnt_x) && !found_q;

  always_comb begin
    unique case (req_mode)
      ModeInsFront: ins_pos_x = '0;
      ModeInsEnd:   ins_pos_x = cnt_x;
      default:      ins_pos_x = pos_x;
    endcase
    unique case (req_mode)
      ModeDelFront: del_pos_x = '0;
      ModeDelEnd:   del_pos_x = cnt_x - XW'(1);
      default:      del_pos_x = pos_x;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    k_d          = k_q;
    target_d     = target_q;
    op_d         = op_q;
    key_d        = key_q;
    found_d      = found_q;
    fidx_d       = fidx_q;
    removed_d    = removed_q;
    load_out     = 1'b0;
    load_status  = StatOk;
    load_element = '0;
    load_index   = '0;
    load_last    = 1'b1;
    cell_cmd     = CmdHold;
    cell_pos     = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          op_d    = req_mode;
          key_d   = in_i.value;
          k_d     = '0;
          found_d = 1'b0;
          priority case (req_mode)
            ModeInsFront, ModeInsEnd, ModeInsPos: begin
              load_out = 1'b1;
              if (full) begin
                load_status = StatFull;
              end else if (ins_pos_x > cnt_x) begin
                load_status = StatBadPos;
              end else begin
                cell_cmd = CmdInsert;
                cell_pos = ins_pos_x[IW-1:0];
                count_d  = count_q + CW'(1);
              end
            end
            ModeDelFront, ModeDelEnd, ModeDelPos: begin
              if (empty) begin
                load_out    = 1'b1;
                load_status = StatEmpty;
              end else if (del_pos_x >= cnt_x) begin
                load_out    = 1'b1;
                load_status = StatBadPos;
              end else begin
                target_d = del_pos_x[IW-1:0];
                state_d  = StScan;
              end
            end
            ModeSearch, ModeDump: begin
              if (empty) begin
                load_out    = 1'b1;
                load_status = StatEmpty;
              end else begin
                state_d = StScan;
              end
            end
            ModeLength: begin
              load_out   = 1'b1;
              load_index = cnt_x[4:0];
            end
            default: begin
            end
          endcase
        end
      end
      StScan: begin
        if (out_free) begin
          cell_cmd = CmdRotate;
          k_d      = last_step ? '0 : k_q + IW'(1);
          priority case (op_q)
            ModeSearch: begin
              if (hit) begin
                found_d = 1'b1;
                fidx_d  = k_q;
              end
              if (last_step) begin
                load_out = 1'b1;
                state_d  = StIdle;
                if (found_q) begin
                  load_index = XW'(fidx_q) <= XW'(31) ? 5'(fidx_q) : 5'(fidx_q);
                end else if (hit) begin
                  load_index = k_x[4:0];
                end else begin
                  load_status = StatNotFound;
                end
              end
            end
            ModeDump: begin
              if (k_x < dump_n_x) begin
                load_out     = 1'b1;
                load_element = cell_data[0];
                load_index   = k_x[4:0];
                load_last    = (k_x + XW'(1) == dump_n_x);
              end
              if (last_step) begin
                state_d = StIdle;
              end
            end
            default: begin
              // delete: catch the entry as it passes the head cell
              if (k_q == target_q) begin
                removed_d = cell_data[0];
              end
              if (last_step) begin
                load_out     = 1'b1;
                load_element = (k_q == target_q) ? cell_data[0] : removed_q;
                state_d      = StShift;
              end
            end
          endcase
        end
      end
      StShift: begin
        cell_cmd = CmdDelete;
        cell_pos = target_q;
        count_d  = count_q - CW'(1);
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    value_t left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = in_i.value;
    end else begin : g_body
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = cell_data[0];
    end else begin : g_mid
      assign right_w = cell_data[g+1];
    end
    bol_cell #(
      .IW (IW),
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cell_cmd),
      .pos_i  (cell_pos),
      .value_i(in_i.value),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      found_q <= found_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q  <= target_d;
    op_q      <= op_d;
    key_q     <= key_d;
    fidx_q    <= fidx_d;
    removed_q <= removed_d;
    if (load_out) begin
      out_status_q  <= load_status;
      out_element_q <= load_element;
      out_index_q   <= load_index;
      out_last_q    <= load_last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.element = out_element_q;
  assign out_o.index   = out_index_q;
  assign out_o.last    = out_last_q;

endmodule
`default_nettype wire

### rtl/bol_cell.sv
// one list slot: holds an entry and shifts toward either neighbor
`default_nettype none
module bol_cell
  import bol_pkg::*;
#(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic      clk_i,
  input  wire cell_cmd_e cmd_i,
  input  wire logic [IW-1:0] pos_i,
  input  wire value_t    value_i,
  input  wire value_t    left_i,
  input  wire value_t    right_i,
  output value_t         data_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  value_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i)
      CmdHold: begin
      end
      CmdInsert: begin
        if (MyIdx > pos_i) begin
          data_d = left_i;
        end else if (MyIdx == pos_i) begin
          data_d = value_i;
        end
      end
      CmdDelete: begin
        if (MyIdx >= pos_i) begin
          data_d = right_i;
        end
      end
      CmdRotate: begin
        data_d = right_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

### tb/bounded_ordered_list_engine_core_tb.sv
// testbench of the list engine: directed and randomized operations checked against a queue model
`timescale 1ns / 100ps
module bounded_ordered_list_engine_core_tb;
  import bol_pkg::*;

  localparam int CAPACITY = 16;
  localparam int TimeoutNs = 4_000_000;

  typedef struct {
    status_e     status;
    value_t      element;
    logic [4:0]  index;
    logic        last;
  } beat_t;

  logic clk_i;
  logic rst_ni;

  bol_in_if  in_if ();
  bol_out_if out_if ();

  bounded_ordered_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  value_t shadow_list[$];
  beat_t  pending_beats[$];
  beat_t  head_beat;

  int errors = 0;
  int ops_sent = 0;
  int ops_ignored = 0;
  int beats_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.value = '0;
    in_if.position = '0;
    out_if.ready = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void push_beat(status_e st, value_t el, int ix, logic lst);
    beat_t b;
    b.status = st;
    b.element = el;
    b.index = 5'(ix);
    b.last = lst;
    pending_beats.push_back(b);
  endfunction

  // expected beats of one accepted request, updating the shadow list
  function automatic void predict_list_op(logic [3:0] mode, value_t val, logic [4:0] pos);
    int n;
    int at;
    int hit;
    value_t removed;
    n = shadow_list.size();
    case (mode)
      ModeInsFront, ModeInsEnd, ModeInsPos: begin
        at = (mode == ModeInsFront) ? 0 : (mode == ModeInsEnd) ? n : int'(pos);
        if (n >= CAPACITY) begin
          push_beat(StatFull, 0, 0, 1'b1);
        end else if (at > n) begin
          push_beat(StatBadPos, 0, 0, 1'b1);
        end else begin
          shadow_list.insert(at, val);
          push_beat(StatOk, 0, 0, 1'b1);
        end
      end
      ModeDelFront, ModeDelEnd, ModeDelPos: begin
        at = (mode == ModeDelFront) ? 0 : (mode == ModeDelEnd) ? ((n == 0) ? 0 : n - 1)
             : int'(pos);
        if (n == 0) begin
          push_beat(StatEmpty, 0, 0, 1'b1);
        end else if (at >= n) begin
          push_beat(StatBadPos, 0, 0, 1'b1);
        end else begin
          removed = shadow_list[at];
          shadow_list.delete(at);
          push_beat(StatOk, removed, 0, 1'b1);
        end
      end
      ModeSearch: begin
        hit = -1;
        for (int i = 0; i < n; i++) begin
          if (hit < 0 && shadow_list[i] == val) hit = i;
        end
        if (n == 0) push_beat(StatEmpty, 0, 0, 1'b1);
        else if (hit < 0) push_beat(StatNotFound, 0, 0, 1'b1);
        else push_beat(StatOk, 0, hit, 1'b1);
      end
      ModeLength: begin
        push_beat(StatOk, 0, n, 1'b1);
      end
      ModeDump: begin
        if (n == 0) begin
          push_beat(StatEmpty, 0, 0, 1'b1);
        end else begin
          if (n > DumpLimit) n = DumpLimit;
          for (int i = 0; i < n; i++) push_beat(StatOk, shadow_list[i], i, i + 1 == n);
        end
      end
      default: begin
        ops_ignored++;
      end
    endcase
  endfunction

  // called at a falling edge; returns at a falling edge with valid possibly still high
  task automatic send_op(logic [3:0] mode, value_t val, logic [4:0] pos);
    in_if.valid <= 1'b1;
    in_if.mode <= mode;
    in_if.value <= val;
    in_if.position <= pos;
    do @(posedge clk_i); while (!in_if.ready);
    predict_list_op(mode, val, pos);
    ops_sent++;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic void check_field(string name, logic signed [63:0] expv,
                                      logic signed [63:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: status %0d element %0d index %0d last %0d",
               out_if.status, out_if.element, out_if.index, out_if.last);
        errors++;
      end else begin
        head_beat = pending_beats.pop_front();
        check_field("status", head_beat.status, out_if.status);
        check_field("element", head_beat.element, out_if.element);
        check_field("index", head_beat.index, out_if.index);
        check_field("last", head_beat.last, out_if.last);
        beats_checked++;
      end
    end
  end

  task automatic test_empty_and_basic();
    // each delete, search, length and dump request on an empty list, then a short list with duplicates
    send_op(ModeDump, 0, 0);
    send_op(ModeDelFront, 0, 0);
    send_op(ModeDelEnd, 0, 0);
    send_op(ModeDelPos, 0, 0);
    send_op(ModeSearch, 0, 0);
    send_op(ModeLength, 0, 0);
    send_op(ModeInsPos, 7, 5'd1);
    send_op(ModeInsPos, 32'sh7fff_ffff, 5'd0);
    send_op(ModeInsFront, 32'sh8000_0000, 5'd31);
    send_op(ModeInsEnd, -1, 0);
    send_op(ModeInsPos, 0, 5'd3);
    send_op(ModeInsPos, -1, 5'd1);
    send_op(ModeSearch, -1, 0);
    send_op(ModeSearch, 32'sh5555_aaaa, 0);
    send_op(ModeLength, 0, 0);
    send_op(ModeDump, 0, 0);
    send_op(ModeDelPos, 0, 5'd31);
    send_op(ModeDelPos, 0, 5'd2);
    send_op(4'd9, 32'sh1234_5678, 5'd4);
    send_op(4'd15, -1, 5'd31);
    send_op(ModeDelEnd, 0, 0);
    send_op(ModeDelFront, 0, 0);
  endtask

  task automatic test_full_list();
    for (int i = 0; i < CAPACITY; i++) send_op(ModeInsEnd, value_t'($urandom), 5'($urandom));
    send_op(ModeInsFront, 1, 0);
    // full takes precedence over a bad position
    send_op(ModeInsPos, 2, 5'd31);
    send_op(ModeDump, 0, 0);
    send_op(ModeSearch, shadow_list[CAPACITY-1], 0);
    send_op(ModeLength, 0, 0);
    send_op(ModeDelPos, 0, 5'(CAPACITY - 1));
    send_op(ModeDelPos, 0, 5'(CAPACITY));
  endtask

  task automatic random_op(int grow_pct);
    logic [3:0] mode;
    value_t val;
    logic [4:0] pos;
    int n;
    int r;
    n = shadow_list.size();
    r = $urandom_range(99);
    if (r < 65) begin
      if ($urandom_range(99) < grow_pct) mode = 4'($urandom_range(2));
      else mode = 4'(3 + $urandom_range(2));
    end else if (r < 77) begin
      mode = ModeSearch;
    end else if (r < 85) begin
      mode = ModeLength;
    end else if (r < 94) begin
      mode = ModeDump;
    end else begin
      mode = 4'($urandom_range(15, 9));
    end
    case ($urandom_range(7))
      0: val = 32'sh8000_0000;
      1: val = 32'sh7fff_ffff;
      2, 3: val = (n > 0) ? shadow_list[$urandom_range(n - 1)] : value_t'($urandom);
      default: val = value_t'($urandom);
    endcase
    if ($urandom_range(9) == 0) pos = 5'($urandom_range(31));
    else if (mode == ModeDelPos) pos = 5'($urandom_range((n > 0) ? n - 1 : 0));
    else pos = 5'($urandom_range(n));
    send_op(mode, val, pos);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int items);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    // grow toward full first, then drain toward empty
    for (int i = 0; i < items; i++) random_op((i < items * 2 / 3) ? 85 : 20);
  endtask

  initial begin
    int guard;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_and_basic();
    test_full_list();
    test_random_phase(0, 0, 34);
    test_random_phase(69, 0, 34);
    test_random_phase(0, 69, 34);
    test_random_phase(15, 15, 34);

    in_if.valid <= 1'b0;
    guard = 0;
    while (pending_beats.size() != 0 && guard < 50000) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_beats.size());
      errors++;
    end
    repeat (4 * CAPACITY) @(negedge clk_i);

    $display("ran %0d requests (%0d with undefined modes) and checked %0d result beats,",
             ops_sent, ops_ignored, beats_checked);
    $display("covering empty and full lists, bad positions and four handshake pressure mixes");
    if (errors == 0) begin
      $display("** bounded_ordered_list_engine_core: PASSED **");
    end else begin
      $display("** bounded_ordered_list_engine_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #TimeoutNs;
    $display("timeout with %0d result beats outstanding", pending_beats.size());
    $display("** bounded_ordered_list_engine_core: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/bol_pkg.sv
rtl/bol_if.sv
rtl/bol_cell.sv
rtl/bounded_ordered_list_engine_core.sv
tb/bounded_ordered_list_engine_core_tb.sv
